// ----- src/ibc_pkg.sv -----
// shared types and constants for the imu bias calibrator
`timescale 1ns / 1ps

package ibc_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int OFS_BITS     = SAMPLE_BITS + 1;
	localparam int CNT_BITS     = 16;
	localparam int GRAV_BITS    = 15;
	localparam int AXES         = 6;
	localparam int AXIS_W       = 3;
	localparam int SUM_BITS_DEF = 32;
	localparam int IDX_BITS     = 8;
	localparam int CFG_BITS     = 16;

	localparam logic [AXIS_W-1:0] AXIS_Z = AXIS_W'(5);
	localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);

	localparam logic [CNT_BITS-1:0]  WINDOW_RESET  = CNT_BITS'(1000);
	localparam logic [GRAV_BITS-1:0] GRAVITY_RESET = GRAV_BITS'(16384);

	localparam logic [IDX_BITS-1:0] REG_WINDOW_LENGTH  = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] REG_GRAVITY_COUNTS = IDX_BITS'(1);

	typedef enum logic {
		CMD_MEASURE   = 1'b0,
		CMD_CALIBRATE = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                          command;
		logic                          read_ok;
		logic signed [SAMPLE_BITS-1:0] gyro_x;
		logic signed [SAMPLE_BITS-1:0] gyro_y;
		logic signed [SAMPLE_BITS-1:0] gyro_z;
		logic signed [SAMPLE_BITS-1:0] accel_x;
		logic signed [SAMPLE_BITS-1:0] accel_y;
		logic signed [SAMPLE_BITS-1:0] accel_z;
	} imu_in_t;

	typedef struct packed {
		logic                          sample_ok;
		logic signed [SAMPLE_BITS-1:0] out_gyro_x;
		logic signed [SAMPLE_BITS-1:0] out_gyro_y;
		logic signed [SAMPLE_BITS-1:0] out_gyro_z;
		logic signed [SAMPLE_BITS-1:0] out_accel_x;
		logic signed [SAMPLE_BITS-1:0] out_accel_y;
		logic signed [SAMPLE_BITS-1:0] out_accel_z;
		logic                          offsets_valid;
		logic                          window_done;
	} imu_out_t;

endpackage

// ----- src/ibc_divider.sv -----
// bit-serial signed divider that turns one axis sum into a saturated offset
`timescale 1ns / 1ps

module ibc_divider #(
	parameter int SUM_BITS = ibc_pkg::SUM_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [SUM_BITS-1:0]             dividend,
	input  logic [ibc_pkg::CNT_BITS-1:0]           divisor,
	input  logic [ibc_pkg::GRAV_BITS-1:0]          gravity,
	output logic                                   done,
	output logic signed [ibc_pkg::OFS_BITS-1:0]    result
);
	import ibc_pkg::*;

	localparam int STEP_W = $clog2(SUM_BITS);
	localparam int WIDE   = SUM_BITS + 2;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_BITS - 1);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_RUN  = 3'b010,
		D_FIN  = 3'b100
	} dstate_t;

	dstate_t             state_q;
	logic [STEP_W-1:0]   step_q;
	logic [SUM_BITS-1:0] dvd_q;
	logic [CNT_BITS-1:0] rem_q;
	logic [CNT_BITS-1:0] dsr_q;
	logic                neg_q;
	logic [WIDE-1:0]     bias_q;

	logic [SUM_BITS-1:0] mag;
	logic [WIDE-1:0]     grav_ext;
	logic [CNT_BITS:0]   part;
	logic [CNT_BITS:0]   part_diff;
	logic                ge;
	logic [WIDE-1:0]     quo_ext;
	logic [WIDE-1:0]     val;
	logic [WIDE-OFS_BITS:0] upper;

	// magnitude of the sum, the most negative value maps to its own magnitude
	assign mag      = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
	assign grav_ext = WIDE'(gravity);

	// restoring step, one quotient bit per cycle
	assign part      = {rem_q, dvd_q[SUM_BITS-1]};
	assign part_diff = part - {1'b0, dsr_q};
	assign ge        = (part >= {1'b0, dsr_q});

	// -q - g is ~q + (1 - g), so one add finishes sign and gravity together
	assign quo_ext = neg_q ? ~{2'b00, dvd_q} : {2'b00, dvd_q};
	assign val     = quo_ext + bias_q;
	assign upper   = val[WIDE-1:OFS_BITS-1];

	always_comb begin
		if ((&upper) || !(|upper)) begin
			result = val[OFS_BITS-1:0];
		end else if (val[WIDE-1]) begin
			result = {1'b1, {(OFS_BITS-1){1'b0}}};
		end else begin
			result = {1'b0, {(OFS_BITS-1){1'b1}}};
		end
	end

	assign done = (state_q == D_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_RUN;
						step_q  <= '0;
					end
				end
				D_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			dvd_q  <= mag;
			rem_q  <= '0;
			dsr_q  <= divisor;
			neg_q  <= dividend[SUM_BITS-1];
			bias_q <= dividend[SUM_BITS-1] ? (WIDE'(1) - grav_ext) : (WIDE'(0) - grav_ext);
		end else if (state_q == D_RUN) begin
			dvd_q <= {dvd_q[SUM_BITS-2:0], ge};
			rem_q <= ge ? part_diff[CNT_BITS-1:0] : part[CNT_BITS-1:0];
		end
	end

endmodule

// ----- src/imu_bias_calibrator.sv -----
// top level of the imu bias calibrator: accumulation, window control and correction
`timescale 1ns / 1ps
// a measure transaction goes from accept through S_EMIT into the output register
// a calibration attempt with a valid sample first passes through S_ACC,
// where the bit-serial adders fold the sample into the six sums
// a window-closing attempt then runs S_DIV,
// where the one shared bit-serial divider is run once per axis
// one transaction at a time; reset clears sums, counts and offsets and drops calibration

module imu_bias_calibrator #(
	parameter int SUM_BITS = ibc_pkg::SUM_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// sample channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ibc_pkg::imu_in_t               in_data,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output ibc_pkg::imu_out_t              out_data,
	// register write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ibc_pkg::IDX_BITS-1:0]   cfg_index,
	input  logic [ibc_pkg::CFG_BITS-1:0]   cfg_data
);
	import ibc_pkg::*;

	localparam int STEP_W = $clog2(SUM_BITS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_BITS - 1);

	// one-hot sequencer
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ACC  = 4'b0010,
		S_DIV  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t                     state_q;
	logic [STEP_W-1:0]          step_q;
	logic                       cmd_q;
	logic                       ok_q;
	logic                       close_q;
	logic [SAMPLE_BITS-1:0]     smp_q   [AXES];
	logic [SAMPLE_BITS-1:0]     raw_q   [AXES];
	logic [AXES-1:0]            carry_q;
	logic [SUM_BITS-1:0]        sum_q   [AXES];
	logic signed [OFS_BITS-1:0] off_q   [AXES];
	logic [CNT_BITS-1:0]        att_q;
	logic [CNT_BITS-1:0]        vcnt_q;
	logic [CNT_BITS-1:0]        dcnt_q;
	logic [AXIS_W-1:0]          axis_q;
	logic                       busy_q;
	logic                       cal_q;
	logic [CNT_BITS-1:0]        wlen_q;
	logic [GRAV_BITS-1:0]       grav_q;
	imu_out_t                   out_q;
	logic                       out_valid_q;

	logic [SAMPLE_BITS-1:0]     in_axes [AXES];
	logic                       accept;
	logic [CNT_BITS-1:0]        att_next;
	logic [CNT_BITS-1:0]        vcnt_next;
	logic                       close_now;
	logic [AXES-1:0]            sum_bit;
	logic [AXES-1:0]            carry_next;
	logic [SAMPLE_BITS-1:0]     corr    [AXES];
	logic                       out_free;
	logic                       div_start;
	logic                       div_done;
	logic signed [OFS_BITS-1:0] div_result;
	imu_out_t                   result;

	// saturate an 18-bit difference to the sample width
	function automatic logic [SAMPLE_BITS-1:0] sat_sample(logic [SAMPLE_BITS+1:0] d);
		logic [2:0] top;
		top = d[SAMPLE_BITS+1:SAMPLE_BITS-1];
		if ((&top) || !(|top)) begin
			return d[SAMPLE_BITS-1:0];
		end else if (d[SAMPLE_BITS+1]) begin
			return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	endfunction

	assign in_axes[0] = in_data.gyro_x;
	assign in_axes[1] = in_data.gyro_y;
	assign in_axes[2] = in_data.gyro_z;
	assign in_axes[3] = in_data.accel_x;
	assign in_axes[4] = in_data.accel_y;
	assign in_axes[5] = in_data.accel_z;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// window bookkeeping, done at accept
	assign att_next  = att_q + 1'b1;
	assign vcnt_next = vcnt_q + CNT_BITS'(in_data.read_ok);
	assign close_now = (att_next >= wlen_q);

	// bit-serial add lanes: sums rotate right, samples shift right with sign fill
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			sum_bit[a]    = sum_q[a][0] ^ smp_q[a][0] ^ carry_q[a];
			carry_next[a] = (sum_q[a][0] & smp_q[a][0]) |
			                (sum_q[a][0] & carry_q[a]) |
			                (smp_q[a][0] & carry_q[a]);
		end
	end

	// correction of a measured sample, raw when not calibrated, zero for calibrate commands or failed reads
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			if (cal_q) begin
				corr[a] = sat_sample({{2{raw_q[a][SAMPLE_BITS-1]}}, raw_q[a]} -
				                     {off_q[a][OFS_BITS-1], off_q[a]});
			end else begin
				corr[a] = raw_q[a];
			end
			if (cmd_q == CMD_CALIBRATE || !ok_q) begin
				corr[a] = '0;
			end
		end
	end

	always_comb begin
		result.sample_ok     = (cmd_q == CMD_MEASURE) && ok_q;
		result.out_gyro_x    = corr[0];
		result.out_gyro_y    = corr[1];
		result.out_gyro_z    = corr[2];
		result.out_accel_x   = corr[3];
		result.out_accel_y   = corr[4];
		result.out_accel_z   = corr[5];
		result.offsets_valid = cal_q;
		result.window_done   = (cmd_q == CMD_CALIBRATE) && close_q;
	end

	assign out_free  = !out_valid_q || out_ready;
	assign div_start = (state_q == S_DIV) && !busy_q;

	// one shared divider, run for each axis in turn
	ibc_divider #(
		.SUM_BITS (SUM_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[axis_q]),
		.divisor  (dcnt_q),
		.gravity  ((axis_q == AXIS_Z) ? grav_q : '0),
		.done     (div_done),
		.result   (div_result)
	);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WINDOW_RESET;
			grav_q <= GRAVITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH:  wlen_q <= cfg_data[CNT_BITS-1:0];
				REG_GRAVITY_COUNTS: grav_q <= cfg_data[GRAV_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, counts, sums and offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			cmd_q   <= CMD_MEASURE;
			ok_q    <= 1'b0;
			close_q <= 1'b0;
			carry_q <= '0;
			att_q   <= '0;
			vcnt_q  <= '0;
			dcnt_q  <= '0;
			axis_q  <= '0;
			busy_q  <= 1'b0;
			cal_q   <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= '0;
				off_q[a] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= in_data.command;
						ok_q    <= in_data.read_ok;
						close_q <= close_now;
						step_q  <= '0;
						carry_q <= '0;
						axis_q  <= '0;
						busy_q  <= 1'b0;
						if (in_data.command == CMD_CALIBRATE) begin
							att_q  <= close_now ? '0 : att_next;
							vcnt_q <= close_now ? '0 : vcnt_next;
							dcnt_q <= vcnt_next;
							if (in_data.read_ok) begin
								state_q <= S_ACC;
							end else if (close_now && vcnt_next != '0) begin
								state_q <= S_DIV;
							end else begin
								// empty window drops calibration
								if (close_now) begin
									cal_q <= 1'b0;
								end
								state_q <= S_EMIT;
							end
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_ACC: begin
					for (int a = 0; a < AXES; a++) begin
						sum_q[a] <= {sum_bit[a], sum_q[a][SUM_BITS-1:1]};
					end
					carry_q <= carry_next;
					step_q  <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						if (!close_q) begin
							state_q <= S_EMIT;
						end else if (dcnt_q != '0) begin
							state_q <= S_DIV;
						end else begin
							cal_q   <= 1'b0;
							state_q <= S_EMIT;
						end
					end
				end
				S_DIV: begin
					if (div_start) begin
						busy_q <= 1'b1;
					end
					if (div_done) begin
						busy_q         <= 1'b0;
						off_q[axis_q]  <= div_result;
						sum_q[axis_q]  <= '0;
						axis_q         <= axis_q + 1'b1;
						if (axis_q == AXIS_LAST) begin
							cal_q   <= 1'b1;
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// sample lanes: raw copy for correction, shifting copy for the adders
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int a = 0; a < AXES; a++) begin
				smp_q[a] <= in_axes[a];
				raw_q[a] <= in_axes[a];
			end
		end else if (state_q == S_ACC) begin
			for (int a = 0; a < AXES; a++) begin
				smp_q[a] <= {smp_q[a][SAMPLE_BITS-1], smp_q[a][SAMPLE_BITS-1:1]};
			end
		end
	end

	// output register, holds a result while the next transaction is taken in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
